// File: hw/rtl/slga_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the spring layout gradient accumulator
// no dependencies

package slga_pkg;

   localparam int WIDE_BITS  = 128;
   localparam int CNT_BITS   = 7;
   localparam int MUL_STEPS  = 64;
   localparam int DIV_STEPS  = 128;
   localparam int SQRT_STEPS = 64;

   // term sequence, one per accumulator
   localparam logic [2:0] TERM_GX  = 3'd0;
   localparam logic [2:0] TERM_GY  = 3'd1;
   localparam logic [2:0] TERM_HXX = 3'd2;
   localparam logic [2:0] TERM_HYY = 3'd3;
   localparam logic [2:0] TERM_HXY = 3'd4;
   localparam int         NUM_TERMS = 5;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_X2,
      ST_Y2,
      ST_SUM,
      ST_ROOT,
      ST_D3,
      ST_LX,
      ST_QX,
      ST_LY,
      ST_QY,
      ST_LY2,
      ST_RXX,
      ST_LX2,
      ST_RYY,
      ST_XY,
      ST_LXY,
      ST_PXY,
      ST_TMUL,
      ST_TCLIP,
      ST_TADD,
      ST_DONE
   } state_type;

endpackage

// File: hw/rtl/slga_alu.sv
`timescale 1ns / 1ps
// shared bit-serial arithmetic unit: shift-add multiply, restoring divide, integer sqrt
// depends on slga_pkg

module slga_alu (
   input  logic                                clock,
   input  logic                                reset,
   input  slga_pkg::alu_req_type               req_in,
   input  logic [slga_pkg::WIDE_BITS-1:0]      opa,
   input  logic [slga_pkg::WIDE_BITS-1:0]      opb,
   output slga_pkg::alu_rsp_type               rsp_out,
   output logic [slga_pkg::WIDE_BITS-1:0]      result
);

   localparam int W = slga_pkg::WIDE_BITS;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   slga_pkg::alu_op_type          op_ff, op_in;
   logic [slga_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [W-1:0]                  acc_ff, acc_in;
   logic [W-1:0]                  a_ff, a_in;
   logic [W-1:0]                  b_ff, b_in;
   logic [W+1:0]                  rem_ff, rem_in;

   logic [W:0]   div_rem;
   logic         div_ge;
   logic [W+1:0] sq_rem;
   logic [W+1:0] sq_trial;
   logic         sq_ge;

   assign div_rem  = {rem_ff[W-1:0], a_ff[W-1]};
   assign div_ge   = div_rem >= {1'b0, b_ff};
   assign sq_rem   = {rem_ff[W-1:0], a_ff[W-1:W-2]};
   assign sq_trial = {acc_ff, 2'b01};
   assign sq_ge    = sq_rem >= sq_trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      if (req_in.start) begin
         busy_in = 1'b1;
         op_in   = req_in.op;
         acc_in  = '0;
         rem_in  = '0;
         a_in    = opa;
         b_in    = opb;
         case (req_in.op)
            slga_pkg::ALU_DIV:  cnt_in = slga_pkg::CNT_BITS'(slga_pkg::DIV_STEPS - 1);
            slga_pkg::ALU_SQRT: cnt_in = slga_pkg::CNT_BITS'(slga_pkg::SQRT_STEPS - 1);
            default:            cnt_in = slga_pkg::CNT_BITS'(slga_pkg::MUL_STEPS - 1);
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            slga_pkg::ALU_DIV: begin
               if (div_ge) begin
                  rem_in = {1'b0, div_rem - {1'b0, b_ff}};
                  acc_in = {acc_ff[W-2:0], 1'b1};
               end else begin
                  rem_in = {1'b0, div_rem};
                  acc_in = {acc_ff[W-2:0], 1'b0};
               end
               a_in = {a_ff[W-2:0], 1'b0};
            end
            slga_pkg::ALU_SQRT: begin
               if (sq_ge) begin
                  rem_in = sq_rem - sq_trial;
                  acc_in = {acc_ff[W-2:0], 1'b1};
               end else begin
                  rem_in = sq_rem;
                  acc_in = {acc_ff[W-2:0], 1'b0};
               end
               a_in = {a_ff[W-3:0], 2'b00};
            end
            default: begin
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
               a_in = {a_ff[W-2:0], 1'b0};
               b_in = {1'b0, b_ff[W-1:1]};
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= slga_pkg::ALU_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
   end

   assign rsp_out.done = done_ff;
   assign result       = acc_ff;

endmodule

// File: hw/rtl/spring_layout_gradient_accumulator_unit.sv
`timescale 1ns / 1ps
// top level of the spring layout gradient accumulator
// depends on slga_pkg and slga_alu

// Accumulates the spring-energy gradient and Hessian terms of one vertex,
// one (anchor, other) pair transaction at a time. All arithmetic runs
// through a single bit-serial unit (shift-add multiply, restoring divide,
// integer square root) under a small sequencer, and the block is not ready
// while a pair is at work. A contributing pair takes fourteen multiplies,
// five divides and one square root, plus acceptance, summing, clipping,
// accumulation and handoff. A self pair or a coincident pair skips the
// arithmetic and goes straight to handoff. On a pair with is_last the five
// saturated sums and the clip flag go into an output register and the sums
// clear; the next pair is accepted while that result waits.

module spring_layout_gradient_accumulator_unit #(
   parameter int FRACTION_BITS = 16,
   parameter int ACCUM_WIDTH   = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_anchor_x,
   input  logic signed [31:0]            req_anchor_y,
   input  logic signed [31:0]            req_other_x,
   input  logic signed [31:0]            req_other_y,
   input  logic [31:0]                   req_stiffness,
   input  logic [31:0]                   req_rest_length,
   input  logic                          req_is_self,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ACCUM_WIDTH-1:0] rsp_grad_x,
   output logic signed [ACCUM_WIDTH-1:0] rsp_grad_y,
   output logic signed [ACCUM_WIDTH-1:0] rsp_hess_xx,
   output logic signed [ACCUM_WIDTH-1:0] rsp_hess_yy,
   output logic signed [ACCUM_WIDTH-1:0] rsp_hess_xy,
   output logic                          rsp_saturated
);

   localparam int W  = slga_pkg::WIDE_BITS;
   localparam int AW = ACCUM_WIDTH;
   localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
   localparam logic [63:0]   ONE_FX  = 64'(1) << FRACTION_BITS;

   // operand capture
   logic [32:0] ax_ff, ax_in, ay_ff, ay_in;
   logic        xneg_ff, xneg_in, yneg_ff, yneg_in;
   logic [31:0] k_ff, k_in, l_ff, l_in;
   logic        last_ff, last_in;

   // intermediate values
   logic [64:0] x2_ff, x2_in, y2_ff, y2_in;
   logic [65:0] s_ff, s_in;
   logic [32:0] d_ff, d_in;
   logic [97:0] d3_ff, d3_in;
   logic [W-1:0] t_ff, t_in;
   logic [63:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [63:0] rxx_ff, rxx_in, ryy_ff, ryy_in, pxy_ff, pxy_in;

   // accumulation
   logic [AW-1:0] sum_ff [slga_pkg::NUM_TERMS];
   logic [AW-1:0] sum_in [slga_pkg::NUM_TERMS];
   logic [AW-1:0] addend_ff, addend_in;
   logic          clip_seen_ff, clip_seen_in;
   logic [2:0]    term_ff, term_in;

   // sequencer
   slga_pkg::state_type state_ff, state_in;
   logic                issued_ff, issued_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] out_ff [slga_pkg::NUM_TERMS];
   logic [AW-1:0] out_in [slga_pkg::NUM_TERMS];
   logic          out_sat_ff, out_sat_in;

   // shared unit
   slga_pkg::alu_req_type alu_req;
   slga_pkg::alu_rsp_type alu_rsp;
   logic [W-1:0]          alu_a, alu_b, alu_res;

   // pair differences at acceptance
   logic [32:0] dx, dy;
   logic [63:0] ax64, ay64;

   // per-term operand and sign
   logic [63:0]   term_m;
   logic          term_neg;
   logic [W-1:0]  term_mag;
   logic [AW-1:0] term_v;
   logic          term_clip;
   logic [AW:0]   add_sum;

   assign dx = {req_anchor_x[31], req_anchor_x} - {req_other_x[31], req_other_x};
   assign dy = {req_anchor_y[31], req_anchor_y} - {req_other_y[31], req_other_y};
   assign ax64 = 64'(ax_ff);
   assign ay64 = 64'(ay_ff);

   // magnitude and sign of the term being accumulated
   always_comb begin
      case (term_ff)
         slga_pkg::TERM_GX: begin
            term_m   = (ax64 >= qx_ff) ? ax64 - qx_ff : qx_ff - ax64;
            term_neg = xneg_ff ^ (ax64 < qx_ff);
         end
         slga_pkg::TERM_GY: begin
            term_m   = (ay64 >= qy_ff) ? ay64 - qy_ff : qy_ff - ay64;
            term_neg = yneg_ff ^ (ay64 < qy_ff);
         end
         slga_pkg::TERM_HXX: begin
            term_m   = (rxx_ff > ONE_FX) ? rxx_ff - ONE_FX : ONE_FX - rxx_ff;
            term_neg = rxx_ff > ONE_FX;
         end
         slga_pkg::TERM_HYY: begin
            term_m   = (ryy_ff > ONE_FX) ? ryy_ff - ONE_FX : ONE_FX - ryy_ff;
            term_neg = ryy_ff > ONE_FX;
         end
         slga_pkg::TERM_HXY: begin
            term_m   = pxy_ff;
            term_neg = xneg_ff ^ yneg_ff;
         end
         default: begin
            term_m   = '0;
            term_neg = 1'b0;
         end
      endcase
   end

   // clip the scaled product into the accumulator range
   always_comb begin
      term_mag  = t_ff >> FRACTION_BITS;
      term_clip = 1'b0;
      term_v    = term_mag[AW-1:0];
      if (term_neg) begin
         if (term_mag > W'(ACC_MIN)) begin
            term_clip = 1'b1;
            term_v    = ACC_MIN;
         end
      end else if (term_mag > W'(ACC_MAX)) begin
         term_clip = 1'b1;
         term_v    = ACC_MAX;
      end
   end

   // saturating add of the held addend
   assign add_sum = {sum_ff[term_ff][AW-1], sum_ff[term_ff]} + {addend_ff[AW-1], addend_ff};

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      xneg_in      = xneg_ff;
      yneg_in      = yneg_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      last_in      = last_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      s_in         = s_ff;
      d_in         = d_ff;
      d3_in        = d3_ff;
      t_in         = t_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rxx_in       = rxx_ff;
      ryy_in       = ryy_ff;
      pxy_in       = pxy_ff;
      sum_in       = sum_ff;
      addend_in    = addend_ff;
      clip_seen_in = clip_seen_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      out_sat_in   = out_sat_ff;
      alu_req.op   = slga_pkg::ALU_MUL;
      alu_a        = '0;
      alu_b        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // operand selection for the shared unit
      case (state_ff)
         slga_pkg::ST_X2: begin
            alu_a = W'(ax_ff);
            alu_b = W'(ax_ff);
         end
         slga_pkg::ST_Y2: begin
            alu_a = W'(ay_ff);
            alu_b = W'(ay_ff);
         end
         slga_pkg::ST_ROOT: begin
            alu_req.op = slga_pkg::ALU_SQRT;
            alu_a      = W'(s_ff);
         end
         slga_pkg::ST_D3: begin
            alu_a = W'(s_ff);
            alu_b = W'(d_ff);
         end
         slga_pkg::ST_LX: begin
            alu_a = W'(l_ff);
            alu_b = W'(ax_ff);
         end
         slga_pkg::ST_LY: begin
            alu_a = W'(l_ff);
            alu_b = W'(ay_ff);
         end
         slga_pkg::ST_QX, slga_pkg::ST_QY: begin
            alu_req.op = slga_pkg::ALU_DIV;
            alu_a      = t_ff;
            alu_b      = W'(d_ff);
         end
         slga_pkg::ST_LY2: begin
            alu_a = W'(y2_ff);
            alu_b = W'(l_ff);
         end
         slga_pkg::ST_LX2: begin
            alu_a = W'(x2_ff);
            alu_b = W'(l_ff);
         end
         slga_pkg::ST_XY: begin
            alu_a = W'(ax_ff);
            alu_b = W'(ay_ff);
         end
         slga_pkg::ST_LXY: begin
            alu_a = t_ff;
            alu_b = W'(l_ff);
         end
         slga_pkg::ST_RXX, slga_pkg::ST_RYY, slga_pkg::ST_PXY: begin
            alu_req.op = slga_pkg::ALU_DIV;
            alu_a      = t_ff << FRACTION_BITS;
            alu_b      = W'(d3_ff);
         end
         slga_pkg::ST_TMUL: begin
            alu_a = W'(k_ff);
            alu_b = W'(term_m);
         end
         default: begin
            alu_a = '0;
         end
      endcase

      // states that use the shared unit issue once, then wait for done
      case (state_ff)
         slga_pkg::ST_IDLE, slga_pkg::ST_SUM, slga_pkg::ST_TCLIP,
         slga_pkg::ST_TADD, slga_pkg::ST_DONE: alu_req.start = 1'b0;
         default:                               alu_req.start = !issued_ff;
      endcase
      if (alu_req.start) begin
         issued_in = 1'b1;
      end
      if (issued_ff && alu_rsp.done) begin
         issued_in = 1'b0;
      end

      case (state_ff)
         slga_pkg::ST_IDLE: begin
            if (req_valid) begin
               ax_in   = dx[32] ? 33'(-dx) : dx;
               ay_in   = dy[32] ? 33'(-dy) : dy;
               xneg_in = dx[32];
               yneg_in = dy[32];
               k_in    = req_stiffness;
               l_in    = req_rest_length;
               last_in = req_is_last;
               // self and coincident pairs add nothing
               if (req_is_self || (dx == '0 && dy == '0)) begin
                  state_in = slga_pkg::ST_DONE;
               end else begin
                  state_in = slga_pkg::ST_X2;
               end
            end
         end
         slga_pkg::ST_X2: if (issued_ff && alu_rsp.done) begin
            x2_in    = alu_res[64:0];
            state_in = slga_pkg::ST_Y2;
         end
         slga_pkg::ST_Y2: if (issued_ff && alu_rsp.done) begin
            y2_in    = alu_res[64:0];
            state_in = slga_pkg::ST_SUM;
         end
         slga_pkg::ST_SUM: begin
            s_in     = 66'(x2_ff) + 66'(y2_ff);
            state_in = slga_pkg::ST_ROOT;
         end
         slga_pkg::ST_ROOT: if (issued_ff && alu_rsp.done) begin
            d_in     = alu_res[32:0];
            state_in = slga_pkg::ST_D3;
         end
         slga_pkg::ST_D3: if (issued_ff && alu_rsp.done) begin
            d3_in    = alu_res[97:0];
            state_in = slga_pkg::ST_LX;
         end
         slga_pkg::ST_LX: if (issued_ff && alu_rsp.done) begin
            t_in     = alu_res;
            state_in = slga_pkg::ST_QX;
         end
         slga_pkg::ST_QX: if (issued_ff && alu_rsp.done) begin
            qx_in    = alu_res[63:0];
            state_in = slga_pkg::ST_LY;
         end
         slga_pkg::ST_LY: if (issued_ff && alu_rsp.done) begin
            t_in     = alu_res;
            state_in = slga_pkg::ST_QY;
         end
         slga_pkg::ST_QY: if (issued_ff && alu_rsp.done) begin
            qy_in    = alu_res[63:0];
            state_in = slga_pkg::ST_LY2;
         end
         slga_pkg::ST_LY2: if (issued_ff && alu_rsp.done) begin
            t_in     = alu_res;
            state_in = slga_pkg::ST_RXX;
         end
         slga_pkg::ST_RXX: if (issued_ff && alu_rsp.done) begin
            rxx_in   = alu_res[63:0];
            state_in = slga_pkg::ST_LX2;
         end
         slga_pkg::ST_LX2: if (issued_ff && alu_rsp.done) begin
            t_in     = alu_res;
            state_in = slga_pkg::ST_RYY;
         end
         slga_pkg::ST_RYY: if (issued_ff && alu_rsp.done) begin
            ryy_in   = alu_res[63:0];
            state_in = slga_pkg::ST_XY;
         end
         slga_pkg::ST_XY: if (issued_ff && alu_rsp.done) begin
            t_in     = alu_res;
            state_in = slga_pkg::ST_LXY;
         end
         slga_pkg::ST_LXY: if (issued_ff && alu_rsp.done) begin
            t_in     = alu_res;
            state_in = slga_pkg::ST_PXY;
         end
         slga_pkg::ST_PXY: if (issued_ff && alu_rsp.done) begin
            pxy_in   = alu_res[63:0];
            term_in  = slga_pkg::TERM_GX;
            state_in = slga_pkg::ST_TMUL;
         end
         slga_pkg::ST_TMUL: if (issued_ff && alu_rsp.done) begin
            t_in     = alu_res;
            state_in = slga_pkg::ST_TCLIP;
         end
         slga_pkg::ST_TCLIP: begin
            addend_in = term_neg ? AW'(-term_v) : term_v;
            if (term_clip) begin
               clip_seen_in = 1'b1;
            end
            state_in = slga_pkg::ST_TADD;
         end
         slga_pkg::ST_TADD: begin
            if (add_sum[AW] != add_sum[AW-1]) begin
               sum_in[term_ff] = add_sum[AW] ? ACC_MIN : ACC_MAX;
               clip_seen_in    = 1'b1;
            end else begin
               sum_in[term_ff] = add_sum[AW-1:0];
            end
            if (term_ff == slga_pkg::TERM_HXY) begin
               state_in = slga_pkg::ST_DONE;
            end else begin
               term_in  = term_ff + 1'b1;
               state_in = slga_pkg::ST_TMUL;
            end
         end
         slga_pkg::ST_DONE: begin
            if (!last_ff) begin
               state_in = slga_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // emit the sums and start the next vertex from zero
               out_in       = sum_ff;
               out_sat_in   = clip_seen_ff;
               rsp_valid_in = 1'b1;
               for (int i = 0; i < slga_pkg::NUM_TERMS; i++) begin
                  sum_in[i] = '0;
               end
               clip_seen_in = 1'b0;
               state_in     = slga_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slga_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slga_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clip_seen_ff <= 1'b0;
         term_ff      <= slga_pkg::TERM_GX;
         for (int i = 0; i < slga_pkg::NUM_TERMS; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         clip_seen_ff <= clip_seen_in;
         term_ff      <= term_in;
         sum_ff       <= sum_in;
      end
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      xneg_ff    <= xneg_in;
      yneg_ff    <= yneg_in;
      k_ff       <= k_in;
      l_ff       <= l_in;
      last_ff    <= last_in;
      x2_ff      <= x2_in;
      y2_ff      <= y2_in;
      s_ff       <= s_in;
      d_ff       <= d_in;
      d3_ff      <= d3_in;
      t_ff       <= t_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      rxx_ff     <= rxx_in;
      ryy_ff     <= ryy_in;
      pxy_ff     <= pxy_in;
      addend_ff  <= addend_in;
      out_ff     <= out_in;
      out_sat_ff <= out_sat_in;
   end

   slga_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .req_in  (alu_req),
      .opa     (alu_a),
      .opb     (alu_b),
      .rsp_out (alu_rsp),
      .result  (alu_res)
   );

   assign req_ready     = (state_ff == slga_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_grad_x    = out_ff[slga_pkg::TERM_GX];
   assign rsp_grad_y    = out_ff[slga_pkg::TERM_GY];
   assign rsp_hess_xx   = out_ff[slga_pkg::TERM_HXX];
   assign rsp_hess_yy   = out_ff[slga_pkg::TERM_HYY];
   assign rsp_hess_xy   = out_ff[slga_pkg::TERM_HXY];
   assign rsp_saturated = out_sat_ff;

endmodule

// File: hw/rtl/slga_checker.sv
`timescale 1ns / 1ps
// port-level checks for the spring layout gradient accumulator, with bind
// depends on spring_layout_gradient_accumulator_unit

module slga_checker #(
   parameter int ACCUM_WIDTH = 48
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [ACCUM_WIDTH-1:0] rsp_grad_x,
   input logic                   rsp_saturated
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an accepted transaction leaves the block not ready in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a transaction was taken");

   // a new result appears only as a transaction finishes
   a_result_at_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (req_ready && !$past(req_ready)))
      else $error("result appeared without a finishing transaction");

   // a stalled result holds
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_grad_x)
         && $stable(rsp_saturated)))
      else $error("stalled result changed");

endmodule

bind spring_layout_gradient_accumulator_unit slga_checker #(
   .ACCUM_WIDTH (ACCUM_WIDTH)
) u_slga_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_grad_x    (rsp_grad_x),
   .rsp_saturated (rsp_saturated)
);
